>>> hw/rtl/ldrf_pkg.sv
// Shared types and constants for the LED matrix chain row flusher.
// Request and mode codes, driver opcodes and the command record passed
// from the front end to the back end. No dependencies.
package ldrf_pkg;

    // Field widths fixed by the request and word formats
    localparam int IDX_W   = 3;
    localparam int VALUE_W = 8;
    localparam int WORD_W  = 16;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [VALUE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0]  t_word;

    // Request codes
    localparam logic [2:0] REQ_ROW_WRITE = 3'd0;
    localparam logic [2:0] REQ_FLUSH_ALL = 3'd1;
    localparam logic [2:0] REQ_FLUSH_DEV = 3'd2;
    localparam logic [2:0] REQ_DEV_CTRL  = 3'd3;
    localparam logic [2:0] REQ_UPDATE_EN = 3'd4;

    // Device control kinds
    localparam logic [2:0] MODE_SHUTDOWN  = 3'd0;
    localparam logic [2:0] MODE_SCANLIMIT = 3'd1;
    localparam logic [2:0] MODE_INTENSITY = 3'd2;
    localparam logic [2:0] MODE_DECODE    = 3'd3;
    localparam logic [2:0] MODE_TEST      = 3'd4;

    // Driver opcodes; digit opcode for row r is OP_DIGIT_BASE + r
    localparam t_byte OP_NOOP       = 8'h00;
    localparam t_byte OP_DIGIT_BASE = 8'h01;
    localparam t_byte OP_DECODE     = 8'h09;
    localparam t_byte OP_BRIGHTNESS = 8'h0A;
    localparam t_byte OP_SCAN_LIM   = 8'h0B;
    localparam t_byte OP_POWER_OFF  = 8'h0C;
    localparam t_byte OP_TEST       = 8'h0F;
    localparam t_byte ALL_ONES      = 8'hFF;
    localparam t_byte SCAN_MAX      = 8'd7;
    localparam t_byte INTENS_MAX    = 8'd15;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_CTRL  = 2'd2
    } t_cmd_kind;

    // One classified request; first doubles as the device of a row write,
    // word holds the control word or the row byte in its low half
    typedef struct packed {
        t_cmd_kind kind;
        t_idx      first;
        t_idx      last;
        t_idx      row;
        t_word     word;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_entry;

endpackage

>>> hw/rtl/ldrf_ifs.sv
// Valid/ready channel interfaces: request channel in, serial word channel out.
// Depends on ldrf_pkg.
interface ldrf_req_if import ldrf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_idx  req_type;
    t_idx  device;
    t_idx  end_device;
    t_idx  row;
    t_byte value;
    t_idx  mode;

    modport source(output valid, req_type, device, end_device, row, value, mode,
                   input ready);
    modport sink(input valid, req_type, device, end_device, row, value, mode,
                 output ready);
endinterface

interface ldrf_word_if import ldrf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word spi_word;
    logic  frame_end;
    logic  last;

    modport source(output valid, spi_word, frame_end, last, input ready);
    modport sink(input valid, spi_word, frame_end, last, output ready);
endinterface

>>> hw/rtl/ldrf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ldrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ldrf_front.sv
// Front end: accepts requests, range-checks them, maps control values and
// pushes one command per useful request. Depends on ldrf_pkg, ldrf_ifs.
module ldrf_front import ldrf_pkg::*; #(
    parameter int NUM_DEVICES = 4,
    parameter int ROWS        = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ldrf_req_if.sink    i_req,
    input  logic        i_q_full,
    output t_q_entry    o_push
);

    localparam t_idx LAST_DEV = t_idx'(NUM_DEVICES - 1);
    localparam t_idx LAST_ROW = t_idx'(ROWS - 1);

    logic  w_accept;
    logic  w_keep;
    t_cmd  w_cmd;
    t_byte w_op;
    t_byte w_data;
    logic  r_update_en;
    logic  n_update_en;

    assign i_req.ready = !i_q_full;
    assign w_accept    = i_req.valid && i_req.ready;

    // Control word mapping
    always_comb begin
        w_op   = OP_NOOP;
        w_data = '0;
        unique case (i_req.mode)
            MODE_SHUTDOWN: begin
                w_op   = OP_POWER_OFF;
                w_data = (i_req.value == '0) ? 8'd1 : 8'd0;
            end
            MODE_SCANLIMIT: begin
                w_op   = OP_SCAN_LIM;
                w_data = (i_req.value > SCAN_MAX) ? SCAN_MAX : i_req.value;
            end
            MODE_INTENSITY: begin
                w_op   = OP_BRIGHTNESS;
                w_data = (i_req.value > INTENS_MAX) ? INTENS_MAX : i_req.value;
            end
            MODE_DECODE: begin
                w_op   = OP_DECODE;
                w_data = (i_req.value == '0) ? 8'd0 : ALL_ONES;
            end
            MODE_TEST: begin
                w_op   = OP_TEST;
                w_data = (i_req.value == '0) ? 8'd0 : 8'd1;
            end
            default: begin
                w_op   = OP_NOOP;
                w_data = '0;
            end
        endcase
    end

    // Request classification
    always_comb begin
        w_keep       = 1'b0;
        n_update_en  = r_update_en;
        w_cmd.kind   = CMD_FLUSH;
        w_cmd.first  = '0;
        w_cmd.last   = LAST_DEV;
        w_cmd.row    = i_req.row;
        w_cmd.word   = {w_op, w_data};
        unique case (i_req.req_type)
            REQ_ROW_WRITE: begin
                w_keep      = (i_req.device <= LAST_DEV) && (i_req.row <= LAST_ROW);
                w_cmd.kind  = CMD_WRITE;
                w_cmd.first = i_req.device;
                w_cmd.word  = {OP_NOOP, i_req.value};
            end
            REQ_FLUSH_ALL: begin
                w_keep = 1'b1;
            end
            REQ_FLUSH_DEV: begin
                w_keep      = (i_req.device <= LAST_DEV);
                w_cmd.first = i_req.device;
                w_cmd.last  = i_req.device;
            end
            REQ_DEV_CTRL: begin
                w_keep      = (i_req.end_device >= i_req.device) &&
                              (i_req.end_device <= LAST_DEV) && (w_op != OP_NOOP);
                w_cmd.kind  = CMD_CTRL;
                w_cmd.first = i_req.device;
                w_cmd.last  = i_req.end_device;
            end
            REQ_UPDATE_EN: begin
                n_update_en = (i_req.value == 8'd1);
                w_keep      = n_update_en;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // Update-enable flag; enabling it triggers a full flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_en <= 1'b1;
        end else if (w_accept) begin
            r_update_en <= n_update_en;
        end
    end

    assign o_push.valid = w_accept && w_keep;
    assign o_push.cmd   = w_cmd;

endmodule

>>> hw/rtl/ldrf_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on ldrf_pkg.
module ldrf_queue import ldrf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_entry i_push,
    input  logic     i_pop,
    output logic     o_full,
    output t_q_entry o_head
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_do_pop;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head.valid;

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/ldrf_back.sv
// Back end: holds the dirty bits and the row store RAM, executes row writes,
// walks flushes row by row and emits frames through an output register.
// Depends on ldrf_pkg, ldrf_ifs, ldrf_ram.
module ldrf_back import ldrf_pkg::*; #(
    parameter int NUM_DEVICES = 4,
    parameter int ROWS        = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_q_entry     i_head,
    output logic         o_pop,
    ldrf_word_if.source  o_word
);

    localparam int   DEV_W    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int   ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int   DEPTH    = NUM_DEVICES * ROWS;
    localparam int   ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam t_idx LAST_DEV = t_idx'(NUM_DEVICES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_idx   r_first, n_first;
    t_idx   r_last, n_last;
    t_idx   r_row, n_row;
    t_idx   r_dev, n_dev;
    logic   r_ctrl, n_ctrl;
    t_word  r_ctrl_word, n_ctrl_word;
    logic [NUM_DEVICES-1:0][ROWS-1:0] r_dirty, n_dirty;

    logic  r_out_valid;
    t_word r_out_word;
    logic  r_out_frame_end;
    logic  r_out_last;

    logic [NUM_DEVICES-1:0] w_dev_mask;
    logic [ROWS-1:0]        w_row_any;
    logic [ROWS-1:0]        w_later;
    logic [NUM_DEVICES-1:0] w_col;
    logic                   w_more;
    logic                   w_cur_any;
    logic [ROW_W-1:0]       w_row_idx;
    logic [DEV_W-1:0]       w_dev_idx;
    logic [DEV_W-1:0]       w_wr_dev;
    logic [ROW_W-1:0]       w_wr_row;
    logic                   w_slot_on;
    t_word                  w_slot_word;
    logic                   w_dev_is_last;
    logic                   w_out_free;
    logic                   w_load;
    logic                   w_clear;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [ADDR_W-1:0]      w_raddr;
    t_byte                  w_rdata;

    assign w_row_idx = r_row[ROW_W-1:0];
    assign w_dev_idx = r_dev[DEV_W-1:0];
    assign w_wr_dev  = i_head.cmd.first[DEV_W-1:0];
    assign w_wr_row  = i_head.cmd.row[ROW_W-1:0];

    // Row store; read address follows the next device/row so data lines up
    assign w_waddr = ADDR_W'(32'(i_head.cmd.first) * ROWS + 32'(i_head.cmd.row));
    assign w_raddr = ADDR_W'(32'(n_dev) * ROWS + 32'(n_row));

    ldrf_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_head.cmd.word[VALUE_W-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Devices covered by the current command
    always_comb begin
        for (int d = 0; d < NUM_DEVICES; d++) begin
            w_dev_mask[d] = (t_idx'(d) >= r_first) && (t_idx'(d) <= r_last);
        end
    end

    // Per-row dirty summary within the range, and rows past the current one
    always_comb begin
        w_col = '0;
        for (int j = 0; j < ROWS; j++) begin
            for (int d = 0; d < NUM_DEVICES; d++) begin
                w_col[d] = r_dirty[d][j];
            end
            w_row_any[j] = |(w_dev_mask & w_col);
            w_later[j]   = (t_idx'(j) > r_row);
        end
    end

    assign w_more    = |(w_row_any & w_later);
    assign w_cur_any = w_row_any[w_row_idx];

    // Slot word for the current device
    assign w_slot_on = w_dev_mask[w_dev_idx] && (r_ctrl || r_dirty[w_dev_idx][w_row_idx]);
    always_comb begin
        if (!w_slot_on) begin
            w_slot_word = '0;
        end else if (r_ctrl) begin
            w_slot_word = r_ctrl_word;
        end else begin
            w_slot_word = {OP_DIGIT_BASE + t_byte'(r_row), w_rdata};
        end
    end

    assign w_dev_is_last = (r_dev == LAST_DEV);
    assign w_out_free    = !r_out_valid || o_word.ready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_last      = r_last;
        n_row       = r_row;
        n_dev       = r_dev;
        n_ctrl      = r_ctrl;
        n_ctrl_word = r_ctrl_word;
        n_dirty     = r_dirty;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_load      = 1'b0;
        w_clear     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.kind)
                        CMD_WRITE: begin
                            w_we                        = 1'b1;
                            n_dirty[w_wr_dev][w_wr_row] = 1'b1;
                        end
                        CMD_FLUSH: begin
                            n_first = i_head.cmd.first;
                            n_last  = i_head.cmd.last;
                            n_row   = '0;
                            n_dev   = '0;
                            n_ctrl  = 1'b0;
                            n_state = S_SCAN;
                        end
                        CMD_CTRL: begin
                            n_first     = i_head.cmd.first;
                            n_last      = i_head.cmd.last;
                            n_dev       = '0;
                            n_ctrl      = 1'b1;
                            n_ctrl_word = i_head.cmd.word;
                            n_state     = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_cur_any) begin
                    n_dev   = '0;
                    n_state = S_EMIT;
                end else if (w_more) begin
                    n_row = r_row + 1'b1;
                end else begin
                    w_clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (!w_dev_is_last) begin
                        n_dev = r_dev + 1'b1;
                    end else if (r_ctrl) begin
                        n_state = S_IDLE;
                    end else if (w_more) begin
                        n_row   = r_row + 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        w_clear = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A finished flush clears the dirty bits of its range
        if (w_clear) begin
            for (int d = 0; d < NUM_DEVICES; d++) begin
                if (w_dev_mask[d]) begin
                    n_dirty[d] = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_dev   <= '0;
            r_ctrl  <= 1'b0;
            r_dirty <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_dev   <= n_dev;
            r_ctrl  <= n_ctrl;
            r_dirty <= n_dirty;
        end
    end

    // Command payload
    always_ff @(posedge i_clk) begin
        r_first     <= n_first;
        r_last      <= n_last;
        r_ctrl_word <= n_ctrl_word;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word      <= w_slot_word;
            r_out_frame_end <= w_dev_is_last;
            r_out_last      <= w_dev_is_last && (r_ctrl || !w_more);
        end
    end

    assign o_word.valid     = r_out_valid;
    assign o_word.spi_word  = r_out_word;
    assign o_word.frame_end = r_out_frame_end;
    assign o_word.last      = r_out_last;

endmodule

>>> hw/rtl/led_matrix_chain_dirty_row_flusher.sv
// Top level of the LED matrix chain row flusher: front end, command queue,
// back end. Depends on ldrf_pkg, ldrf_ifs, ldrf_front, ldrf_queue, ldrf_back.
//
// Keeps NUM_DEVICES x ROWS row bytes with a dirty bit each and turns requests
// into 16-bit serial words, one frame of NUM_DEVICES words per dirty row or
// per control request, device 0 first, no-op words in idle slots. Requests
// enter a two-entry queue and are accepted whenever it has room, also while
// the back end is busy or a word waits on the output; requests that cause
// nothing are dropped at the front and never reach the back end. The back
// end takes each command from the queue in its idle state, which is all a
// row write needs. A flush then scans its rows one by one and sends a frame
// for each row with a dirty bit in its range, passing over clean rows; a
// device control request sends a single frame. Emitting waits while the
// output register holds a word that is not taken. Row bytes live in one RAM
// with a registered read; dirty bits are flip-flops cleared by reset.
module led_matrix_chain_dirty_row_flusher import ldrf_pkg::*; #(
    parameter int NUM_DEVICES = 4,
    parameter int ROWS        = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ldrf_req_if.sink     i_req,
    ldrf_word_if.source  o_word
);

    t_q_entry w_push;
    t_q_entry w_head;
    logic     w_q_full;
    logic     w_pop;

    ldrf_front #(
        .NUM_DEVICES(NUM_DEVICES),
        .ROWS       (ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    ldrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    ldrf_back #(
        .NUM_DEVICES(NUM_DEVICES),
        .ROWS       (ROWS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_word  (o_word)
    );

    // The final word of a request always closes a frame
    a_last_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid && o_word.last |-> o_word.frame_end)
        else $error("last word does not end a frame");

    // Every emitted opcode is a no-op, a digit row or a control register
    a_legal_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.spi_word[15:8] == OP_NOOP) ||
            ((o_word.spi_word[15:8] >= OP_DIGIT_BASE) &&
             (o_word.spi_word[15:8] <= t_byte'(ROWS))) ||
            (o_word.spi_word[15:8] == OP_DECODE) ||
            (o_word.spi_word[15:8] == OP_BRIGHTNESS) ||
            (o_word.spi_word[15:8] == OP_SCAN_LIM) ||
            (o_word.spi_word[15:8] == OP_POWER_OFF) ||
            (o_word.spi_word[15:8] == OP_TEST))
        else $error("illegal opcode on output");

    // A no-op slot carries zero data
    a_noop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid && (o_word.spi_word[15:8] == OP_NOOP) |->
            (o_word.spi_word[7:0] == 8'd0))
        else $error("no-op slot with data");

    // Reset leaves no word pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_word.valid)
        else $error("output valid after reset");

endmodule
